// File: rtl/fkc_pkg.sv
// Shared types, constants and reset values for the fan keypad controller.
package fkc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [1:0] CFG_LOW_POWER  = 2'd2;
  localparam logic [1:0] CFG_MAX_MIN    = 2'd3;

  localparam int CFG_DATA_W = 16;

  // Fan drive codes
  localparam logic [1:0] DRIVE_OFF  = 2'd0;
  localparam logic [1:0] DRIVE_FULL = 2'd1;
  localparam logic [1:0] DRIVE_PWM  = 2'd2;

  localparam logic [15:0] HOLD_DONE = 16'hFFFF;
  localparam logic [13:0] LOW_MAX   = 14'd16383;
  localparam logic [2:0]  LEVEL_MAX = 3'd4;

  // Register reset values
  localparam logic [6:0]  DEBOUNCE_RST   = 7'd70;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1600;
  localparam logic [13:0] LOW_POWER_RST  = 14'd10000;
  localparam logic [5:0]  MAX_MIN_RST    = 6'd63;
  localparam logic [2:0]  LEVEL_RST      = 3'd4;
  localparam logic [5:0]  MINUTES_RST    = 6'd5;

  typedef struct packed {
    logic [6:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [13:0] low_power_ticks;
    logic [5:0]  max_minutes;
  } cfg_t;

  typedef struct packed {
    logic key_mode;
    logic key_minus;
    logic key_plus;
    logic blink_phase;
    logic supply_low;
  } item_t;

  typedef struct packed {
    logic [5:0] led_pattern;
    logic [1:0] fan_mode;
    logic [1:0] pwm_setting;
    logic       running;
    logic       power_down;
  } result_t;

  typedef struct packed {
    logic        wait_release;
    logic [6:0]  debounce_count;
    logic [15:0] hold_count;
    logic [2:0]  fan_level;
    logic [5:0]  minutes_value;
    logic        level_mode;
    logic        run_flag;
    logic [13:0] low_count;
    logic [1:0]  drive_mode;
    logic [1:0]  pwm_select;
  } ctl_state_t;

endpackage

// File: rtl/fkc_cfg_regs.sv
// Configuration register file for the fan keypad controller.
module fkc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [fkc_pkg::CFG_DATA_W-1:0] wr_data,
  output fkc_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= fkc_pkg::DEBOUNCE_RST;
      cfg.long_press_ticks <= fkc_pkg::LONG_PRESS_RST;
      cfg.low_power_ticks  <= fkc_pkg::LOW_POWER_RST;
      cfg.max_minutes      <= fkc_pkg::MAX_MIN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        fkc_pkg::CFG_DEBOUNCE:   cfg.debounce_ticks   <= wr_data[6:0];
        fkc_pkg::CFG_LONG_PRESS: cfg.long_press_ticks <= wr_data[15:0];
        fkc_pkg::CFG_LOW_POWER:  cfg.low_power_ticks  <= wr_data[13:0];
        fkc_pkg::CFG_MAX_MIN:    cfg.max_minutes      <= wr_data[5:0];
        default:                 cfg.max_minutes      <= cfg.max_minutes;
      endcase
    end
  end

endmodule

// File: rtl/fkc_step.sv
// Per-tick next-state and result logic of the fan keypad controller.
module fkc_step (
  input  fkc_pkg::cfg_t       cfg,
  input  fkc_pkg::ctl_state_t cur,
  input  fkc_pkg::item_t      item,
  output fkc_pkg::ctl_state_t nxt,
  output fkc_pkg::result_t    res
);

  always_comb begin
    logic       any_key;
    logic       held;
    logic       active;
    logic [7:0] db_inc;
    logic       pd;
    logic [5:0] led;
    logic [2:0] shift;
    logic [13:0] lc;

    nxt     = cur;
    pd      = 1'b0;
    led     = 6'd0;
    held    = 1'b0;
    db_inc  = 8'd0;
    shift   = 3'd0;
    lc      = 14'd0;
    any_key = item.key_mode | item.key_minus | item.key_plus;

    // Key tracking and debounce window
    if (any_key) begin
      held             = cur.wait_release;
      nxt.wait_release = 1'b1;
    end else if (cur.wait_release) begin
      nxt.wait_release   = 1'b0;
      nxt.debounce_count = 7'd1;
    end
    if (nxt.debounce_count != 7'd0) begin
      db_inc = {1'b0, nxt.debounce_count} + 8'd1;
      if (db_inc > {1'b0, cfg.debounce_ticks}) nxt.debounce_count = 7'd0;
      else nxt.debounce_count = db_inc[6:0];
    end
    active = any_key && (nxt.debounce_count == 7'd0);

    if (active) begin
      if (item.key_mode) begin
        if (cur.hold_count < cfg.long_press_ticks) begin
          nxt.hold_count = cur.hold_count + 16'd1;
        end else if (cur.hold_count != fkc_pkg::HOLD_DONE) begin
          nxt.hold_count = fkc_pkg::HOLD_DONE;
          nxt.run_flag   = ~cur.run_flag;
          if (!nxt.run_flag) begin
            nxt.drive_mode = fkc_pkg::DRIVE_OFF;
          end else if (cur.fan_level >= fkc_pkg::LEVEL_MAX) begin
            nxt.drive_mode = fkc_pkg::DRIVE_FULL;
          end else begin
            nxt.drive_mode = fkc_pkg::DRIVE_PWM;
            nxt.pwm_select = 2'(cur.fan_level - 3'd1);
          end
        end
      end else if (!held) begin
        // Fresh plus or minus press steps level or minutes
        if (item.key_minus) begin
          if (cur.level_mode && cur.fan_level > 3'd1) begin
            nxt.fan_level = cur.fan_level - 3'd1;
          end else if (!cur.level_mode && cur.minutes_value > 6'd1) begin
            nxt.minutes_value = cur.minutes_value - 6'd1;
          end
        end else begin
          if (cur.level_mode && cur.fan_level < fkc_pkg::LEVEL_MAX) begin
            nxt.fan_level = cur.fan_level + 3'd1;
          end else if (!cur.level_mode && cur.minutes_value < cfg.max_minutes) begin
            nxt.minutes_value = cur.minutes_value + 6'd1;
          end
        end
        if (cur.run_flag && (nxt.fan_level != cur.fan_level)) begin
          if (nxt.fan_level >= fkc_pkg::LEVEL_MAX) begin
            nxt.drive_mode = fkc_pkg::DRIVE_FULL;
          end else begin
            nxt.drive_mode = fkc_pkg::DRIVE_PWM;
            nxt.pwm_select = 2'(nxt.fan_level - 3'd1);
          end
        end
      end
    end else begin
      // Release of a short mode press flips level/time display
      if (cur.hold_count != 16'd0) begin
        if (cur.hold_count != fkc_pkg::HOLD_DONE) nxt.level_mode = ~cur.level_mode;
        nxt.hold_count = 16'd0;
      end
      shift = nxt.fan_level - 3'd1;
      if (nxt.level_mode) led = 6'd1 << shift;
      else if (item.blink_phase) led = nxt.minutes_value;
    end

    // Low supply shutdown
    if (item.supply_low) begin
      lc = cur.low_count;
      if (lc < fkc_pkg::LOW_MAX) lc = lc + 14'd1;
      nxt.low_count = lc;
      if (lc > cfg.low_power_ticks) begin
        nxt.run_flag   = 1'b0;
        nxt.drive_mode = fkc_pkg::DRIVE_OFF;
        pd             = 1'b1;
      end
    end

    res.led_pattern = led;
    res.fan_mode    = nxt.drive_mode;
    res.pwm_setting = nxt.pwm_select;
    res.running     = nxt.run_flag;
    res.power_down  = pd;
  end

endmodule

// File: rtl/fan_keypad_controller_unit.sv
// Top level of the fan keypad controller: input word register, state and result register.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       key_mode_pressed .. supply_low
//  out      source     out_valid / out_stall     led_pattern .. power_down
//  cfg      sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One word per cycle sustained while out_stall is low; the accept edge loads the input
//  register, and the result register loads from the step logic when that word advances.
//  The step logic between the two registers makes one pass per word.
//  Reset (rst, synchronous) empties both registers and loads state and config defaults.
//  out_stall holds the result register; the input register still takes one more word,
//  then in_stall rises until the result moves on. cfg_ready is always high.
module fan_keypad_controller_unit (
  input  logic        clk,
  input  logic        rst,
  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        key_mode_pressed,
  input  logic        key_minus_pressed,
  input  logic        key_plus_pressed,
  input  logic        blink_phase,
  input  logic        supply_low,
  // result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  led_pattern,
  output logic [1:0]  fan_mode,
  output logic [1:0]  pwm_setting,
  output logic        running,
  output logic        power_down,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [fkc_pkg::CFG_DATA_W-1:0] cfg_data
);

  fkc_pkg::cfg_t       cfg;
  fkc_pkg::item_t      in_q;
  logic                in_q_valid;
  fkc_pkg::ctl_state_t ctl;
  fkc_pkg::ctl_state_t ctl_next;
  fkc_pkg::result_t    res_next;
  fkc_pkg::result_t    res_q;
  logic                in_take;
  logic                advance;

  assign cfg_ready = 1'b1;

  fkc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held word when the result register is empty or draining
  assign advance  = in_q_valid & (~out_valid | ~out_stall);
  assign in_stall = in_q_valid & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  // Capture the input word; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q.key_mode    <= key_mode_pressed;
      in_q.key_minus   <= key_minus_pressed;
      in_q.key_plus    <= key_plus_pressed;
      in_q.blink_phase <= blink_phase;
      in_q.supply_low  <= supply_low;
    end
  end

  fkc_step u_step (
    .cfg  (cfg),
    .cur  (ctl),
    .item (in_q),
    .nxt  (ctl_next),
    .res  (res_next)
  );

  // Controller state advances once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.wait_release   <= 1'b0;
      ctl.debounce_count <= 7'd0;
      ctl.hold_count     <= 16'd0;
      ctl.fan_level      <= fkc_pkg::LEVEL_RST;
      ctl.minutes_value  <= fkc_pkg::MINUTES_RST;
      ctl.level_mode     <= 1'b1;
      ctl.run_flag       <= 1'b0;
      ctl.low_count      <= 14'd0;
      ctl.drive_mode     <= fkc_pkg::DRIVE_OFF;
      ctl.pwm_select     <= 2'd0;
    end else if (advance) begin
      ctl <= ctl_next;
    end
  end

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign led_pattern = res_q.led_pattern;
  assign fan_mode    = res_q.fan_mode;
  assign pwm_setting = res_q.pwm_setting;
  assign running     = res_q.running;
  assign power_down  = res_q.power_down;

endmodule

// File: rtl/fkc_checker.sv
// Port-level checker for the fan keypad controller, bound to the top level.
module fkc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  led_pattern,
  input logic [1:0]  fan_mode,
  input logic [1:0]  pwm_setting,
  input logic        running,
  input logic        power_down
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(led_pattern) && $stable(fan_mode)
      && $stable(running) && $stable(power_down))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Fan is driven exactly when running
  a_run_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (running == (fan_mode != fkc_pkg::DRIVE_OFF)))
    else $error("fan drive disagrees with running");

  a_pd_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && power_down |-> !running && fan_mode == fkc_pkg::DRIVE_OFF)
    else $error("power-down with fan still driven");

  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && fan_mode == fkc_pkg::DRIVE_PWM |-> pwm_setting != 2'd3)
    else $error("PWM setting out of range");

endmodule

bind fan_keypad_controller_unit fkc_checker u_fkc_checker (.*);
